// ----- rtl/core/lcfir_pkg.sv -----
// ----------------------------------------------------------------------------
// lcfir_pkg: shared constants and types of the linear convolution FIR
// Widths, memory depth, input action codes and the MAC control struct.
// ----------------------------------------------------------------------------
package lcfir_pkg;

  // Kernel and delay line depth, and the data widths.
  localparam int MAX_TAPS = 64;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int IDX_W    = $clog2(MAX_TAPS);

  // Fixed field widths of the channels and the register.
  localparam int TAP_IDX_W = 6;
  localparam int TC_W      = 7;
  localparam int SUM_W     = 38;

  // APB register file: one register, the 7-bit tap count, at byte address 0.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_TAP_COUNT = '0;

  // Input action codes.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic [IDX_W-1:0]           idx_t;

  // Control that travels with one tap read through the MAC pipeline.
  typedef struct packed {
    logic en;
    logic first;
    logic fin;
  } mac_ctl_t;

endpackage

// ----- rtl/core/lcfir_if.sv -----
// ----------------------------------------------------------------------------
// lcfir_if: valid/ready channel interfaces of the linear convolution FIR
// The input channel carries load and sample items, the output channel sums.
// ----------------------------------------------------------------------------
interface lcfir_in_if
  import lcfir_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [TAP_IDX_W-1:0] tap_index;
  coef_t                tap_value;
  sample_t              sample;
  logic                 last_sample;

  modport source (output valid, action, tap_index, tap_value, sample, last_sample,
                  input ready);
  modport sink (input valid, action, tap_index, tap_value, sample, last_sample,
                output ready);
endinterface

interface lcfir_out_if
  import lcfir_pkg::*;
  ();
  logic       valid;
  logic       ready;
  sum_t       sum;
  logic       is_last;

  modport source (output valid, sum, is_last, input ready);
  modport sink (input valid, sum, is_last, output ready);
endinterface

// ----- rtl/core/lcfir_ram.sv -----
// ----------------------------------------------------------------------------
// lcfir_ram: single-port-write, registered-read RAM with per-entry valid bits
// An entry never written since the last clear reads as zero.
// ----------------------------------------------------------------------------
module lcfir_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clr,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[raddr];
      if (clr) begin
        vld_r <= '0;
      end else if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

// ----- rtl/core/lcfir_mac.sv -----
// ----------------------------------------------------------------------------
// lcfir_mac: multiply-accumulate pipeline for one tap per cycle
// One product register, then the accumulator; done pulses with the full sum.
// ----------------------------------------------------------------------------
module lcfir_mac
  import lcfir_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mac_ctl_t ctl,
  input  coef_t    coef,
  input  sample_t  samp,
  output sum_t     acc,
  output logic     done
);

  mac_ctl_t                  ctl_d1_r;
  mac_ctl_t                  ctl_d2_r;
  logic signed [PROD_W-1:0]  prod_r;
  sum_t                      acc_r;
  logic                      done_r;

  // Control is delayed to line up with the registered RAM data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d1_r <= '0;
      ctl_d2_r <= '0;
      done_r   <= 1'b0;
    end else begin
      ctl_d1_r <= ctl;
      ctl_d2_r <= ctl_d1_r;
      done_r   <= ctl_d2_r.en && ctl_d2_r.fin;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= coef * samp;
    if (ctl_d2_r.en) begin
      acc_r <= ctl_d2_r.first ? SUM_W'(prod_r) : acc_r + SUM_W'(prod_r);
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

// ----- rtl/core/lcfir_apb.sv -----
// ----------------------------------------------------------------------------
// lcfir_apb: APB register file holding the tap count
// Writes land on the access phase; pready is always high.
// ----------------------------------------------------------------------------
module lcfir_apb
  import lcfir_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [TC_W-1:0]   tap_count
);

  logic [TC_W-1:0] tap_count_r;
  logic            hit;

  assign hit = (paddr[APB_AW-1:2] == REG_TAP_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TC_W'(1);
    end else if (psel && penable && pwrite && hit) begin
      tap_count_r <= pwdata[TC_W-1:0];
    end
  end

  assign prdata    = hit ? APB_DW'(tap_count_r) : '0;
  assign pready    = 1'b1;
  assign tap_count = tap_count_r;

endmodule

// ----- rtl/core/linear_convolution_fir.sv -----
// ----------------------------------------------------------------------------
// linear_convolution_fir: direct-form FIR giving the full linear convolution
// Each sample item gives one sum; a sample marked last adds taps-1 tail sums.
// Samples are taken one at a time: no new item is accepted until the sum
// and any tail are in the output register. The shared multiplier reads one
// tap a cycle from the kernel and delay-line memories; a load stays in IDLE.
// Reset (synchronous, rst_n low) clears valid bits at once: no clearing pass.
// ----------------------------------------------------------------------------
module linear_convolution_fir
  import lcfir_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  lcfir_in_if.sink          in_ch,
  lcfir_out_if.source       out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // The delay line is a circular buffer: wp_r points at the newest sample,
  // so tap k of the model lives at entry wp_r - k (mod MAX_TAPS). Shifting
  // in a sample is a single write at wp_r + 1, which overwrites the oldest.
  function automatic idx_t ptr_inc(input idx_t p);
    return (p == idx_t'(MAX_TAPS - 1)) ? '0 : p + idx_t'(1);
  endfunction

  function automatic idx_t ptr_dec(input idx_t p);
    return (p == '0) ? idx_t'(MAX_TAPS - 1) : p - idx_t'(1);
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t          state_r;
  idx_t            wp_r;
  idx_t            rd_ptr_r;
  idx_t            k_r;
  idx_t            taps_m1_r;
  idx_t            tail_cnt_r;
  logic            last_r;
  logic            out_valid_r;
  sum_t            sum_r;
  logic            is_last_r;

  logic [TC_W-1:0] tap_count;
  idx_t            taps_m1;
  logic            in_fire;
  logic            emit_go;
  logic            tail_more;
  logic            dl_we;
  idx_t            dl_waddr;
  sample_t         dl_wdata;
  logic            dl_clr;
  logic            kn_we;
  sample_t         dl_rdata;
  coef_t           kn_rdata;
  mac_ctl_t        mac_ctl;
  sum_t            mac_acc;
  logic            mac_done;

  lcfir_apb u_apb (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .tap_count (tap_count)
  );

  // Active tap count: zero acts as one tap, and counts above the depth
  // saturate at the depth. Kept as count minus one so it fits an index.
  always_comb begin
    if (tap_count == '0) begin
      taps_m1 = '0;
    end else if (32'(tap_count) > MAX_TAPS) begin
      taps_m1 = idx_t'(MAX_TAPS - 1);
    end else begin
      taps_m1 = idx_t'(tap_count - TC_W'(1));
    end
  end

  // New items are taken only while idle, never during a tail. A finished sum may still sit in
  // the output register while the next item is transferred.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign tail_more = last_r && (tail_cnt_r != '0);

  // Delay-line writes: the item's sample on transfer, and a zero for each
  // tail step. After the final sum of a signal all entries read as zero.
  always_comb begin
    dl_we    = 1'b0;
    dl_waddr = ptr_inc(wp_r);
    dl_wdata = in_ch.sample;
    if (in_fire && (in_ch.action == ACT_SAMPLE)) begin
      dl_we = 1'b1;
    end else if (emit_go && tail_more) begin
      dl_we    = 1'b1;
      dl_wdata = '0;
    end
  end

  assign dl_clr = emit_go && last_r && (tail_cnt_r == '0);

  // Loads beyond the store depth are dropped.
  assign kn_we = in_fire && (in_ch.action == ACT_LOAD) &&
                 (32'(in_ch.tap_index) < MAX_TAPS);

  lcfir_ram #(
    .DEPTH (MAX_TAPS),
    .WIDTH (SAMPLE_W)
  ) u_delay_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (dl_clr),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (rd_ptr_r),
    .rdata (dl_rdata)
  );

  lcfir_ram #(
    .DEPTH (MAX_TAPS),
    .WIDTH (COEF_W)
  ) u_kernel_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (1'b0),
    .we    (kn_we),
    .waddr (idx_t'(in_ch.tap_index)),
    .wdata (in_ch.tap_value),
    .raddr (k_r),
    .rdata (kn_rdata)
  );

  // One tap is issued per cycle in RUN; the control rides alongside the
  // read so the MAC knows the first and the final product of the sum.
  always_comb begin
    mac_ctl.en    = (state_r == ST_RUN);
    mac_ctl.first = (k_r == '0);
    mac_ctl.fin   = (k_r == taps_m1_r);
  end

  lcfir_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .coef  (kn_rdata),
    .samp  (dl_rdata),
    .acc   (mac_acc),
    .done  (mac_done)
  );

  // Sequencer, pointers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      rd_ptr_r    <= '0;
      k_r         <= '0;
      taps_m1_r   <= '0;
      tail_cnt_r  <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // A new sum loaded in EMIT keeps the output register full instead.
      if (out_valid_r && out_ch.ready && !emit_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire && (in_ch.action == ACT_SAMPLE)) begin
            wp_r       <= ptr_inc(wp_r);
            rd_ptr_r   <= ptr_inc(wp_r);
            k_r        <= '0;
            taps_m1_r  <= taps_m1;
            last_r     <= in_ch.last_sample;
            tail_cnt_r <= in_ch.last_sample ? taps_m1 : '0;
            state_r    <= ST_RUN;
          end
        end
        ST_RUN: begin
          k_r      <= k_r + idx_t'(1);
          rd_ptr_r <= ptr_dec(rd_ptr_r);
          if (k_r == taps_m1_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (mac_done) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid_r <= 1'b1;
            sum_r       <= mac_acc;
            is_last_r   <= last_r && (tail_cnt_r == '0);
            if (tail_more) begin
              // Shift a zero in and run the next tail sum.
              wp_r       <= ptr_inc(wp_r);
              rd_ptr_r   <= ptr_inc(wp_r);
              k_r        <= '0;
              tail_cnt_r <= tail_cnt_r - idx_t'(1);
              state_r    <= ST_RUN;
            end else begin
              last_r  <= 1'b0;
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.sum     = sum_r;
  assign out_ch.is_last = is_last_r;

  // The MAC only finishes a sum while the sequencer waits for it.
  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r == ST_DRAIN))
    else $error("MAC finished a sum outside the drain state");

  // The tap counter never runs past the active tap count.
  a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (k_r <= taps_m1_r))
    else $error("tap counter ran past the active tap count");

  // Tail steps are pending only for a sample marked last.
  a_tail_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_cnt_r != '0) |-> last_r)
    else $error("tail steps pending without a last sample");

  // After the final sum of a signal is emitted the block is idle again.
  a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dl_clr |=> (state_r == ST_IDLE) && out_valid_r && is_last_r)
    else $error("final sum did not leave the block idle with is_last set");

endmodule

// ----- test/linear_convolution_fir_tb.sv -----
// ----------------------------------------------------------------------------
// linear_convolution_fir_tb: self-checking testbench of the convolution FIR
// Loads kernels over the input channel, sets the tap count over APB, streams
// signals and compares every sum and last flag with a local predictor.
// ----------------------------------------------------------------------------
module linear_convolution_fir_tb
  import lcfir_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 11;
  // Settling time, covering any load or sum still being worked on after the
  // last expected result has come out.
  localparam int SETTLE_CYCLES = 100;
  // Long receiver hold-off used to fill the block and stall its input.
  localparam int HOLD_CYCLES   = 400;
  // Kernel length of the full-scale signal.
  localparam int FULL_SCALE_TAPS = 16;

  localparam logic [APB_AW-1:0] TAP_COUNT_ADDR = {REG_TAP_COUNT, 2'b00};

  localparam sample_t SAMPLE_MIN = 16'sh8000;
  localparam sample_t SAMPLE_MAX = 16'sh7FFF;
  localparam coef_t   COEF_MIN   = 16'sh8000;
  localparam coef_t   COEF_MAX   = 16'sh7FFF;

  // One expected output transfer.
  typedef struct {
    sum_t sum;
    logic is_last;
  } conv_out_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  lcfir_in_if  in_if ();
  lcfir_out_if out_if ();

  linear_convolution_fir dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #CLK_HALF clk = ~clk;

  // Predictor state: its own kernel, delay line and tap count register.
  coef_t            kernel_m [MAX_TAPS];
  sample_t          delay_m  [MAX_TAPS];
  logic [TC_W-1:0]  tap_count_m;

  // Sums that the block still owes, oldest first.
  conv_out_t pending_sums[$];

  int mismatches;

  // Idling knobs, in percent of cycles, and the receiver hold-off counter.
  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // A count of zero acts as one tap; anything above the depth saturates.
  function automatic int active_taps();
    if (tap_count_m == '0) return 1;
    if (int'(tap_count_m) > MAX_TAPS) return MAX_TAPS;
    return int'(tap_count_m);
  endfunction

  function automatic void shift_delay(input sample_t s);
    for (int k = MAX_TAPS - 1; k > 0; k--) delay_m[k] = delay_m[k-1];
    delay_m[0] = s;
  endfunction

  // Appends the dot product of kernel and delay line over the active taps.
  // The accumulator is 38 bits wide, so any overflow wraps as in hardware.
  function automatic void push_sum(input int taps);
    conv_out_t r;
    r.sum     = '0;
    r.is_last = 1'b0;
    for (int k = 0; k < taps; k++) r.sum = r.sum + sum_t'(kernel_m[k]) * sum_t'(delay_m[k]);
    pending_sums.push_back(r);
  endfunction

  // Applies one accepted input transfer to the predictor.
  function automatic void predict_item(input logic act, input logic [TAP_IDX_W-1:0] idx,
                                       input coef_t val, input sample_t smp, input logic last);
    int taps;
    if (act == ACT_LOAD) begin
      if (int'(idx) < MAX_TAPS) kernel_m[idx] = val;
      return;
    end
    // The tap count is fixed when the sample arrives and holds for its tail.
    taps = active_taps();
    shift_delay(smp);
    push_sum(taps);
    if (last) begin
      // The tail shifts in zeros until every sample has left the active taps.
      for (int i = 1; i < taps; i++) begin
        shift_delay('0);
        push_sum(taps);
      end
      pending_sums[pending_sums.size()-1].is_last = 1'b1;
      for (int k = 0; k < MAX_TAPS; k++) delay_m[k] = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result checker: every output transfer is matched against the oldest sum.
  // Sampling at the clock edge sees the values that the transfer carried.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_sums
    conv_out_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected output transfer: sum %0d, is_last %0b", out_if.sum, out_if.is_last);
        mismatches++;
      end else begin
        want = pending_sums.pop_front();
        if (out_if.sum !== want.sum) begin
          $error("sum mismatch: expected %0d, got %0d", want.sum, out_if.sum);
          mismatches++;
        end
        if (out_if.is_last !== want.is_last) begin
          $error("is_last mismatch: expected %0b, got %0b", want.is_last, out_if.is_last);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, or a solid hold-off while hold_left counts down.
  // --------------------------------------------------------------------------
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared stimulus tasks
  // --------------------------------------------------------------------------

  // Offers one item, after a random gap, and returns at the edge of its
  // transfer. Valid stays high so that a following item can go back to back.
  task automatic send_item(input logic act, input logic [TAP_IDX_W-1:0] idx,
                           input coef_t val, input sample_t smp, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.action      <= act;
    in_if.tap_index   <= idx;
    in_if.tap_value   <= val;
    in_if.sample      <= smp;
    in_if.last_sample <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_item(act, idx, val, smp, last);
  endtask

  // The fields that an item does not use carry random values throughout.
  task automatic load_coef(input logic [TAP_IDX_W-1:0] idx, input coef_t val);
    sample_t junk_sample;
    logic    junk_last;
    junk_sample = sample_t'($urandom);
    junk_last   = 1'($urandom);
    send_item(ACT_LOAD, idx, val, junk_sample, junk_last);
  endtask

  task automatic send_sample(input sample_t smp, input logic last);
    logic [TAP_IDX_W-1:0] junk_idx;
    coef_t                junk_val;
    junk_idx = TAP_IDX_W'($urandom);
    junk_val = coef_t'($urandom);
    send_item(ACT_SAMPLE, junk_idx, junk_val, smp, last);
  endtask

  // Stops offering, waits for every owed sum, then lets the block settle.
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the tap count, then a read back of the same register.
  // Bits above the register carry random values on the write.
  task automatic write_tap_count(input logic [TC_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TAP_COUNT_ADDR;
    pwdata  <= {(APB_DW-TC_W)'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tap_count_m = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[TC_W-1:0] !== value) begin
      $error("tap_count read mismatch: expected %0d, got %0d", value, prdata[TC_W-1:0]);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Samples lean toward the extremes, zero and minus one.
  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2: return '0;
      3: return '1;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Mostly short kernels keep the run quick; the rest hit the edges or pick a longer count.
  function automatic logic [TC_W-1:0] pick_tap_count();
    case ($urandom_range(9))
      0: return '0;
      1: return TC_W'(MAX_TAPS);
      2: return '1;
      3: return TC_W'($urandom_range(MAX_TAPS - 1, 9));
      default: return TC_W'($urandom_range(8, 1));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // After reset the kernel is zero and one tap is active. A single tap with
  // a last sample gives exactly one sum, flagged last, with no tail.
  task automatic test_reset_single_tap();
    send_sample(SAMPLE_MAX, 1'b0);
    load_coef('0, COEF_MIN);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);
    wait_drain();
  endtask

  // Full depth with the coefficients at both ends and in the middle; the
  // last sample flushes a tail of sixty-three zeros.
  task automatic test_full_depth_tail();
    write_tap_count(TC_W'(MAX_TAPS));
    load_coef('0, COEF_MIN);
    load_coef('1, COEF_MAX);
    load_coef(TAP_IDX_W'(31), '1);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample('1, 1'b0);
    send_sample('0, 1'b1);
    wait_drain();
  endtask

  // A count of zero acts as one tap and a count above the depth saturates.
  task automatic test_tap_count_limits();
    write_tap_count('0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b1);
    wait_drain();
    write_tap_count('1);
    send_sample(SAMPLE_MIN, 1'b1);
    wait_drain();
  endtask

  // The tap count changes between two samples of one signal: the new count
  // applies from the next sum while the delay line keeps its history.
  task automatic test_count_change_in_signal();
    write_tap_count(TC_W'(3));
    load_coef(TAP_IDX_W'(1), 16'sd3);
    load_coef(TAP_IDX_W'(2), -16'sd7);
    load_coef(TAP_IDX_W'(4), 16'sd11);
    send_sample(16'sd100, 1'b0);
    send_sample(-16'sd200, 1'b0);
    send_sample(16'sd300, 1'b0);
    wait_drain();
    write_tap_count(TC_W'(5));
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd9, 1'b1);
    wait_drain();
  endtask

  // One random phase under the given idling. Most of it is well-formed
  // signals: a few kernel loads, then samples ending in a last sample. The
  // rest is loose items with random action and last flag.
  task automatic test_random_phase(input int n_items, input int idle_pct, input int stall_pct);
    int sent;
    int n_loads;
    int n_samples;
    wait_drain();
    write_tap_count(pick_tap_count());
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 7) begin
        n_loads   = $urandom_range(3);
        n_samples = $urandom_range(6, 1);
        repeat (n_loads) load_coef(TAP_IDX_W'($urandom), coef_t'($urandom));
        for (int s = 0; s < n_samples; s++) send_sample(pick_sample(), s == n_samples - 1);
        sent += n_loads + n_samples;
      end else begin
        if ($urandom_range(1) == 0) load_coef(TAP_IDX_W'($urandom), coef_t'($urandom));
        else send_sample(pick_sample(), 1'($urandom_range(1)));
        sent++;
      end
    end
    wait_drain();
  endtask

  // Every coefficient and sample at the negative extreme drives the sum to
  // the largest magnitude for this kernel length, well past 32 bits, then
  // the tail walks it back down.
  task automatic test_full_scale();
    write_tap_count(TC_W'(FULL_SCALE_TAPS));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int k = 0; k < FULL_SCALE_TAPS; k++) load_coef(TAP_IDX_W'(k), COEF_MIN);
    for (int s = 0; s < FULL_SCALE_TAPS; s++) begin
      send_sample(SAMPLE_MIN, s == FULL_SCALE_TAPS - 1);
    end
    wait_drain();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering samples, so the block fills and stalls its input. Then the
  // sender pauses mid-signal until every owed sum has come out.
  task automatic test_backpressure();
    write_tap_count(TC_W'(4));
    send_idle_pct  = 0;
    recv_stall_pct = 15;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    repeat (16) send_sample(pick_sample(), 1'b0);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (3) send_sample(pick_sample(), 1'b0);
    send_sample(pick_sample(), 1'b1);
    wait_drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Every input of the block has a known value from time zero.
    rst_n             <= 1'b0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    in_if.valid       <= 1'b0;
    in_if.action      <= ACT_LOAD;
    in_if.tap_index   <= '0;
    in_if.tap_value   <= '0;
    in_if.sample      <= '0;
    in_if.last_sample <= 1'b0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    tap_count_m    = TC_W'(1);
    for (int k = 0; k < MAX_TAPS; k++) begin
      kernel_m[k] = '0;
      delay_m[k]  = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed checks run without idling on either side.
    test_reset_single_tap();
    test_full_depth_tail();
    test_tap_count_limits();
    test_count_change_in_signal();

    // Random phases: none, sender idle, receiver stalling, both idling.
    test_random_phase(18, 0, 0);
    test_random_phase(18, 82, 0);
    test_random_phase(18, 0, 82);
    test_random_phase(18, 15, 15);

    test_full_scale();
    test_backpressure();

    wait_drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- linear_convolution_fir.f -----
rtl/core/lcfir_pkg.sv
rtl/core/lcfir_if.sv
rtl/core/lcfir_ram.sv
rtl/core/lcfir_mac.sv
rtl/core/lcfir_apb.sv
rtl/core/linear_convolution_fir.sv
test/linear_convolution_fir_tb.sv
